// ===== rtl/bitmap_range_engine_macros.svh =====
// Assertion macros used by the checker file of the bitmap range engine.
`ifndef BITMAP_RANGE_ENGINE_MACROS_SVH
`define BITMAP_RANGE_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BRE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BRE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bre_pkg.sv =====
// Shared types and constants of the bitmap range engine.
package bre_pkg;

    // Command codes
    localparam logic [2:0] OP_SET    = 3'd0;
    localparam logic [2:0] OP_CLEAR  = 3'd1;
    localparam logic [2:0] OP_TOGGLE = 3'd2;
    localparam logic [2:0] OP_ALL    = 3'd3;
    localparam logic [2:0] OP_ANY    = 3'd4;

    // Bytes-in-use register
    localparam int         CFG_W     = 13;
    localparam logic [12:0] CFG_RESET = 13'd4096;

    // Byte index of any run position (run end of an in-bounds run stays below 2^16 bits)
    localparam int BYTE_IDX_W = 13;

    // Command queue between front and back
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = 2;
    localparam int CMDQ_CNT_W = 3;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [14:0] first_bit;
        logic [15:0] range_length;
    } in_item_t;

    typedef struct packed {
        logic answer;
        logic out_of_bounds;
    } out_item_t;

    // Classified command as handed to the back end
    typedef struct packed {
        logic [2:0]            op;
        logic                  walk;
        logic                  oob;
        logic [BYTE_IDX_W-1:0] first_byte;
        logic [BYTE_IDX_W-1:0] last_byte;
        logic [2:0]            first_off;
        logic [2:0]            last_off;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_WALK,
        BK_DRAIN,
        BK_DONE
    } back_state_t;

endpackage

// ===== rtl/bre_front.sv =====
// Front end: config register, input acceptance, bounds check and run decode.
module bre_front #(
    parameter int MAP_BYTES = 4096
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [bre_pkg::CFG_W-1:0]  cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  bre_pkg::in_item_t          in_data,
    input  logic                       q_full,
    input  logic                       clearing,
    output logic                       q_push,
    output bre_pkg::cmd_t              q_cmd
);

    logic [bre_pkg::CFG_W-1:0] bytes_in_use_reg;
    logic [11:0]               start_byte;
    logic [16:0]               eff_bytes;
    logic [19:0]               eff_bits;
    logic [16:0]               run_end;
    logic [16:0]               last_pos;
    logic                      op_known;
    logic                      run_oob;

    // Config register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_in_use_reg <= bre_pkg::CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            bytes_in_use_reg <= cfg_data;
        end
    end

    // Bounds check against the effective byte count
    always_comb
    begin
        start_byte = in_data.first_bit[14:3];
        if (17'(bytes_in_use_reg) > 17'(MAP_BYTES))
        begin
            eff_bytes = 17'(MAP_BYTES);
        end
        else
        begin
            eff_bytes = 17'(bytes_in_use_reg);
        end
        eff_bits = {eff_bytes, 3'b000};
        run_end  = 17'(in_data.first_bit) + 17'(in_data.range_length);
        last_pos = run_end - 17'd1;
        op_known = (in_data.opcode <= bre_pkg::OP_ANY);
        run_oob  = (17'(start_byte) >= eff_bytes) || (20'(run_end) > eff_bits);
    end

    // Classified command
    always_comb
    begin
        q_cmd.op         = in_data.opcode;
        q_cmd.oob        = op_known && run_oob;
        q_cmd.walk       = op_known && !run_oob && (in_data.range_length != 16'd0);
        q_cmd.first_byte = bre_pkg::BYTE_IDX_W'(start_byte);
        q_cmd.last_byte  = last_pos[15:3];
        q_cmd.first_off  = in_data.first_bit[2:0];
        q_cmd.last_off   = last_pos[2:0];
    end

    // Hold off while the queue is full or the map is being cleared
    assign in_stall = q_full || clearing;
    assign q_push   = in_valid && !in_stall;

endmodule

// ===== rtl/bre_fifo.sv =====
// Small command queue between the front and back ends.
module bre_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bre_pkg::cmd_t push_data,
    input  logic          pop,
    output bre_pkg::cmd_t pop_data,
    output logic          full,
    output logic          not_empty
);

    bre_pkg::cmd_t                   slot_reg [bre_pkg::CMDQ_DEPTH];
    logic [bre_pkg::CMDQ_PTR_W-1:0]  wr_ptr_reg;
    logic [bre_pkg::CMDQ_PTR_W-1:0]  rd_ptr_reg;
    logic [bre_pkg::CMDQ_CNT_W-1:0]  count_reg;
    logic [bre_pkg::CMDQ_CNT_W-1:0]  count_next;

    assign full      = (count_reg == bre_pkg::CMDQ_CNT_W'(bre_pkg::CMDQ_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Payload slots
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/bre_back.sv =====
// Back end: bitmap memory, clearing pass, byte walk and result register.
module bre_back #(
    parameter int MAP_BYTES = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  bre_pkg::cmd_t      q_cmd,
    output logic               q_pop,
    output logic               clearing,
    output logic               out_valid,
    input  logic               out_stall,
    output bre_pkg::out_item_t out_data
);

    localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;

    logic [7:0] mem [MAP_BYTES];

    bre_pkg::back_state_t              state_reg, state_next;
    bre_pkg::cmd_t                     cmd_reg, cmd_next;
    logic [bre_pkg::BYTE_IDX_W-1:0]    cur_reg, cur_next;
    logic [AW-1:0]                     clr_reg, clr_next;
    logic                              pend_valid_reg, pend_valid_next;
    logic [7:0]                        pend_mask_reg, pend_mask_next;
    logic [AW-1:0]                     pend_addr_reg, pend_addr_next;
    logic [7:0]                        rd_data_reg;
    logic                              all_reg, all_next;
    logic                              any_reg, any_next;
    bre_pkg::out_item_t                res_reg, res_next;
    logic                              out_valid_reg, out_valid_next;
    bre_pkg::out_item_t                out_data_reg, out_data_next;

    logic                              rd_en;
    logic [AW-1:0]                     rd_addr;
    logic                              wr_en;
    logic [AW-1:0]                     wr_addr;
    logic [7:0]                        wr_data;
    logic [7:0]                        head_mask;
    logic [7:0]                        tail_mask;
    logic                              all_upd;
    logic                              any_upd;
    logic [7:0]                        masked;
    logic                              is_modify;

    // Masks of the byte being issued
    always_comb
    begin
        head_mask = (cur_reg == cmd_reg.first_byte) ? (8'hFF >> cmd_reg.first_off) : 8'hFF;
        tail_mask = (cur_reg == cmd_reg.last_byte)
                    ? (8'hFF << (3'd7 - cmd_reg.last_off)) : 8'hFF;
    end

    // Update stage: byte read last cycle is tested or rewritten
    always_comb
    begin
        masked    = rd_data_reg & pend_mask_reg;
        is_modify = (cmd_reg.op == bre_pkg::OP_SET) || (cmd_reg.op == bre_pkg::OP_CLEAR)
                    || (cmd_reg.op == bre_pkg::OP_TOGGLE);
        all_upd   = all_reg;
        any_upd   = any_reg;
        if (pend_valid_reg)
        begin
            all_upd = all_reg && (masked == pend_mask_reg);
            any_upd = any_reg || (masked != 8'h00);
        end
        case (cmd_reg.op)
            bre_pkg::OP_SET:    wr_data = rd_data_reg | pend_mask_reg;
            bre_pkg::OP_CLEAR:  wr_data = rd_data_reg & ~pend_mask_reg;
            bre_pkg::OP_TOGGLE: wr_data = rd_data_reg ^ pend_mask_reg;
            default:            wr_data = rd_data_reg;
        endcase
    end

    // Sequencer: next state and outputs
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        cur_next        = cur_reg;
        clr_next        = clr_reg;
        pend_valid_next = 1'b0;
        pend_mask_next  = pend_mask_reg;
        pend_addr_next  = pend_addr_reg;
        all_next        = all_upd;
        any_next        = any_upd;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_data_next   = out_data_reg;
        q_pop           = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = AW'(cur_reg);
        wr_en           = pend_valid_reg && is_modify;
        wr_addr         = pend_addr_reg;

        unique case (state_reg)
            bre_pkg::BK_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(MAP_BYTES - 1))
                begin
                    state_next = bre_pkg::BK_IDLE;
                end
            end
            bre_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop                  = 1'b1;
                    cmd_next               = q_cmd;
                    cur_next               = q_cmd.first_byte;
                    all_next               = 1'b1;
                    any_next               = 1'b0;
                    res_next.answer        = 1'b0;
                    res_next.out_of_bounds = q_cmd.oob;
                    state_next = q_cmd.walk ? bre_pkg::BK_WALK : bre_pkg::BK_DONE;
                end
            end
            bre_pkg::BK_WALK:
            begin
                rd_en           = 1'b1;
                pend_valid_next = 1'b1;
                pend_mask_next  = head_mask & tail_mask;
                pend_addr_next  = AW'(cur_reg);
                cur_next        = cur_reg + 1'b1;
                if (cur_reg == cmd_reg.last_byte)
                begin
                    state_next = bre_pkg::BK_DRAIN;
                end
            end
            bre_pkg::BK_DRAIN:
            begin
                if (cmd_reg.op == bre_pkg::OP_ALL)
                begin
                    res_next.answer = all_upd;
                end
                else if (cmd_reg.op == bre_pkg::OP_ANY)
                begin
                    res_next.answer = any_upd;
                end
                state_next = bre_pkg::BK_DONE;
            end
            bre_pkg::BK_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = bre_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = bre_pkg::BK_IDLE;
            end
        endcase
    end

    // State register and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bre_pkg::BK_CLEAR;
            clr_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        cur_reg       <= cur_next;
        pend_mask_reg <= pend_mask_next;
        pend_addr_reg <= pend_addr_next;
        all_reg       <= all_next;
        any_reg       <= any_next;
        res_reg       <= res_next;
        out_data_reg  <= out_data_next;
    end

    // Bitmap memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= (state_reg == bre_pkg::BK_CLEAR) ? 8'h00 : wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign clearing  = (state_reg == bre_pkg::BK_CLEAR);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== rtl/bitmap_range_engine.sv =====
// Top level of the bitmap range engine: front end, command queue and back end.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------------
//   in      | in        | in_valid/in_stall  | in_data: opcode, first_bit, length
//   out     | out       | out_valid/out_stall| out_data: answer, out_of_bounds
//   cfg     | in        | cfg_valid/cfg_ready| cfg_data: bytes_in_use
//
// A run touching N bytes passes in the back end through the byte walk (one memory read
// per byte), an update step and a result step; errors and empty runs go straight to
// the result step. The walk does a read-modify-write of one byte per cycle over the bitmap
// memory. After reset a clearing pass over all MAP_BYTES bytes runs with in_stall high.
// The queue holds up to 4 classified transactions while the back end or the
// output is stalled; the result register lets the next walk run under a stall.
module bitmap_range_engine #(
    parameter int MAP_BYTES = 4096
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [bre_pkg::CFG_W-1:0]  cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  bre_pkg::in_item_t          in_data,
    output logic                       out_valid,
    input  logic                       out_stall,
    output bre_pkg::out_item_t         out_data
);

    logic          q_push;
    logic          q_pop;
    logic          q_full;
    logic          q_not_empty;
    logic          clearing;
    bre_pkg::cmd_t push_cmd;
    bre_pkg::cmd_t pop_cmd;

    bre_front #(
        .MAP_BYTES (MAP_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .q_full    (q_full),
        .clearing  (clearing),
        .q_push    (q_push),
        .q_cmd     (push_cmd)
    );

    bre_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_cmd),
        .pop       (q_pop),
        .pop_data  (pop_cmd),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    bre_back #(
        .MAP_BYTES (MAP_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_not_empty),
        .q_cmd     (pop_cmd),
        .q_pop     (q_pop),
        .clearing  (clearing),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ===== rtl/bre_checker.sv =====
// Port-level checker for the bitmap range engine, bound to the top level.
`include "bitmap_range_engine_macros.svh"

module bre_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input bre_pkg::out_item_t out_data
);

    logic [3:0] pending_reg;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid && !out_stall;

    // Transactions accepted but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (in_xfer && !out_xfer)
        begin
            pending_reg <= pending_reg + 1'b1;
        end
        else if (out_xfer && !in_xfer)
        begin
            pending_reg <= pending_reg - 1'b1;
        end
    end

    `BRE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
    `BRE_ASSERT_NOW(a_no_phantom, out_valid, pending_reg != 4'd0, "result without accepted transaction")
    `BRE_ASSERT_NOW(a_bounded, 1'b1, pending_reg <= 4'd6, "more transactions in flight than storage")
    `BRE_ASSERT_NOW(a_excl_flags, out_valid, !(out_data.answer && out_data.out_of_bounds), "answer set on error")

endmodule

bind bitmap_range_engine bre_checker u_bre_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
